// ===== sv/cva_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cva_pkg
// Shared types and arithmetic helpers of the color vibrance adjuster.
// ---------------------------------------------------------------------------
package cva_pkg;

	typedef enum logic [1:0] {
		MODE_PASS  = 2'b00,
		MODE_BOOST = 2'b01,
		MODE_GRAY  = 2'b10
	} mode_t;

	localparam logic [7:0] VIB_NEUTRAL = 8'd128;

	// classified request, front to back
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  k;
		logic [7:0]  vm;
		logic [7:0]  hn;
		logic [15:0] l;
		logic [8:0]  den;
		logic [10:0] hbase;
		logic        hsub;
	} cls_t;

	// restoring divider partial state
	typedef struct packed {
		logic [25:0] rem;
		logic [17:0] q;
	} div_t;

	function automatic div_t div_step(input div_t a, input logic [16:0] dvs,
			input logic [4:0] sh);
		logic [33:0] t;
		logic [33:0] rw;
		div_t        o;
		t = {17'd0, dvs} << sh;
		rw = {8'd0, a.rem};
		o.q = {a.q[16:0], 1'b0};
		if (rw >= t) begin
			o.rem = a.rem - t[25:0];
			o.q[0] = 1'b1;
		end else begin
			o.rem = a.rem;
		end
		return o;
	endfunction

endpackage
`default_nettype wire

// ===== sv/color_vibrance_adjust.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// color_vibrance_adjust
// Adjusts an 8-bit RGB color by the vibrance setting.
// ---------------------------------------------------------------------------
// Takes one color per cycle while the queue is not full and returns one result
// per cycle while results are popped. A request passes through the request
// queue and then through the sixteen stages of the back pipeline, whose
// saturation and value dividers resolve three quotient bits
// per stage. A stalled result holds the pipeline; the request queue keeps
// taking up to QUEUE_DEPTH requests meanwhile. Write vibrance only while the
// block is idle.
module color_vibrance_adjust
	import cva_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       vibrance_valid,
	output logic            vibrance_ready,
	input  wire logic [7:0] vibrance,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] red_in,
	input  wire logic [7:0] green_in,
	input  wire logic [7:0] blue_in,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out
);

	cls_t cls;
	cls_t head;
	logic head_valid;
	logic take;

	cva_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.vibrance_valid (vibrance_valid),
		.vibrance_ready (vibrance_ready),
		.vibrance       (vibrance),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.cls            (cls)
	);

	cva_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push && !full),
		.wr_data  (cls),
		.full     (full),
		.rd_en    (take),
		.rd_valid (head_valid),
		.rd_data  (head)
	);

	cva_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (head_valid),
		.in_data   (head),
		.in_take   (take),
		.empty     (empty),
		.pop       (pop),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

endmodule
`default_nettype wire

// ===== sv/cva_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cva_front
// Vibrance register and classifier: picks the operation and derives the
// max/min, lightness, divisor and hue terms of each request.
// ---------------------------------------------------------------------------
module cva_front
	import cva_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       vibrance_valid,
	output logic            vibrance_ready,
	input  wire logic [7:0] vibrance,
	input  wire logic [7:0] red_in,
	input  wire logic [7:0] green_in,
	input  wire logic [7:0] blue_in,
	output cls_t            cls
);

	logic [7:0] vib_q;
	logic [7:0] v;
	logic [7:0] m;
	logic [8:0] sum;

	assign vibrance_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vib_q <= VIB_NEUTRAL;
		end else if (vibrance_valid) begin
			vib_q <= vibrance;
		end
	end

	always_comb begin
		v = (red_in > green_in) ? red_in : green_in;
		m = (red_in < green_in) ? red_in : green_in;
		if (blue_in > v) v = blue_in;
		if (blue_in < m) m = blue_in;
		sum = {1'b0, v} + {1'b0, m};

		cls.r = red_in;
		cls.g = green_in;
		cls.b = blue_in;
		cls.k = vib_q;
		cls.vm = v - m;
		cls.l = {sum, 7'd0};
		cls.den = sum[8] ? (9'd0 - sum) : sum;
		if (vib_q == VIB_NEUTRAL) cls.mode = MODE_PASS;
		else if (vib_q > VIB_NEUTRAL) cls.mode = MODE_BOOST;
		else cls.mode = MODE_GRAY;

		priority if (red_in == v) begin
			if (green_in == m) begin
				cls.hn = v - blue_in;  cls.hbase = 11'd1280; cls.hsub = 1'b0;
			end else begin
				cls.hn = v - green_in; cls.hbase = 11'd256;  cls.hsub = 1'b1;
			end
		end else if (green_in == v) begin
			if (blue_in == m) begin
				cls.hn = v - red_in;   cls.hbase = 11'd256;  cls.hsub = 1'b0;
			end else begin
				cls.hn = v - blue_in;  cls.hbase = 11'd768;  cls.hsub = 1'b1;
			end
		end else begin
			if (red_in == m) begin
				cls.hn = v - green_in; cls.hbase = 11'd768;  cls.hsub = 1'b0;
			end else begin
				cls.hn = v - red_in;   cls.hbase = 11'd1280; cls.hsub = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/cva_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cva_queue
// Short FIFO of classified requests between front and back.
// ---------------------------------------------------------------------------
module cva_queue
	import cva_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire cls_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output logic      rd_valid,
	output cls_t      rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cls_t          mem_q [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd_en) rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			unique case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/cva_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cva_back
// Sixteen-stage pipeline: saturation and hue dividers, HSL adjust, HSL to
// RGB with a value divider, gray blend; the last stage is the result.
// ---------------------------------------------------------------------------
module cva_back
	import cva_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire cls_t       in_data,
	output logic            in_take,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      red_out,
	output logic [7:0]      green_out,
	output logic [7:0]      blue_out
);

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  k;
		logic [7:0]  vm;
		logic [15:0] l;
		logic [8:0]  den;
		logic [10:0] hbase;
		logic        hsub;
		div_t        sd;
		div_t        hd;
		logic [15:0] gsum;
		logic [10:0] h;
		logic [16:0] s;
		logic [24:0] ps;
		logic [22:0] pl;
		logic [33:0] pv;
		logic [16:0] vv;
		logic [16:0] mm;
		logic [25:0] p1;
		logic [33:0] p2;
	} work_t;

	function automatic logic [7:0] sat8(input logic [18:0] x);
		return (x[18:16] != 3'd0) ? 8'd255 : x[15:8];
	endfunction

	function automatic logic [7:0] blend(input logic [7:0] k, input logic [7:0] c,
			input logic [7:0] gr);
		logic [15:0] t;
		t = 16'(k[6:0] * c) + 16'((7'd127 - k[6:0]) * gr);
		return t[14:7];
	endfunction

	work_t wk_s1, wk_s2, wk_s3, wk_s4, wk_s5, wk_s6, wk_s7, wk_s8;
	work_t wk_s9, wk_s10, wk_s11, wk_s12, wk_s13, wk_s14, wk_s15, wk_s16;
	work_t nx [1:16];
	logic [16:1] vld_s;
	logic        en;

	logic [7:0]  d;
	logic [6:0]  c2;
	logic [15:0] dl;
	logic [17:0] op;
	logic [18:0] v19;
	logic [18:0] m19;
	logic [16:0] dv;
	logic [17:0] vsf;
	logic [18:0] mid1;
	logic [18:0] mid2;
	logic [18:0] xv;
	logic [18:0] xm;
	logic [7:0]  gr;

	assign en = !vld_s[16] || pop;
	assign in_take = in_valid && en;
	assign empty = !vld_s[16];
	assign red_out = wk_s16.r;
	assign green_out = wk_s16.g;
	assign blue_out = wk_s16.b;

	always_comb begin
		// s1: load, start dividers, gray weight
		nx[1] = '0;
		nx[1].mode = in_data.mode;
		nx[1].r = in_data.r;
		nx[1].g = in_data.g;
		nx[1].b = in_data.b;
		nx[1].k = in_data.k;
		nx[1].vm = in_data.vm;
		nx[1].l = in_data.l;
		nx[1].den = in_data.den;
		nx[1].hbase = in_data.hbase;
		nx[1].hsub = in_data.hsub;
		nx[1].sd.rem = {2'd0, in_data.vm, 16'd0};
		nx[1].hd.rem = {10'd0, in_data.hn, 8'd0};
		nx[1].gsum = 16'(in_data.b * 7'd77) + 16'(in_data.r * 7'd84)
			+ 16'(in_data.g * 7'd95);
		for (int i = 0; i < 3; i++) begin
			nx[1].sd = div_step(nx[1].sd, {8'd0, in_data.den}, 5'(17 - i));
			nx[1].hd = div_step(nx[1].hd, {9'd0, in_data.vm}, 5'(8 - i));
		end

		// s2
		nx[2] = wk_s1;
		gr = wk_s1.gsum[15:8];
		for (int i = 0; i < 3; i++) begin
			nx[2].sd = div_step(nx[2].sd, {8'd0, wk_s1.den}, 5'(14 - i));
			nx[2].hd = div_step(nx[2].hd, {9'd0, wk_s1.vm}, 5'(5 - i));
		end
		if (wk_s1.mode == MODE_GRAY) begin
			nx[2].r = blend(wk_s1.k, wk_s1.r, gr);
			nx[2].g = blend(wk_s1.k, wk_s1.g, gr);
			nx[2].b = blend(wk_s1.k, wk_s1.b, gr);
		end

		// s3: finish hue
		nx[3] = wk_s2;
		for (int i = 0; i < 3; i++) begin
			nx[3].sd = div_step(nx[3].sd, {8'd0, wk_s2.den}, 5'(11 - i));
			nx[3].hd = div_step(nx[3].hd, {9'd0, wk_s2.vm}, 5'(2 - i));
		end
		if (wk_s2.vm == 8'd0) nx[3].h = '0;
		else if (wk_s2.hsub) nx[3].h = wk_s2.hbase - nx[3].hd.q[10:0];
		else nx[3].h = wk_s2.hbase + nx[3].hd.q[10:0];

		nx[4] = wk_s3;
		for (int i = 0; i < 3; i++)
			nx[4].sd = div_step(nx[4].sd, {8'd0, wk_s3.den}, 5'(8 - i));

		nx[5] = wk_s4;
		for (int i = 0; i < 3; i++)
			nx[5].sd = div_step(nx[5].sd, {8'd0, wk_s4.den}, 5'(5 - i));

		// s6: finish saturation
		nx[6] = wk_s5;
		for (int i = 0; i < 3; i++)
			nx[6].sd = div_step(nx[6].sd, {8'd0, wk_s5.den}, 5'(2 - i));
		nx[6].s = (wk_s5.vm == 8'd0) ? 17'd0 : nx[6].sd.q[16:0];

		// s7: adjust products
		nx[7] = wk_s6;
		d = 8'(9'd256 - {1'b0, wk_s6.k});
		c2 = 7'(d[7:1]) + 7'd64;
		dl = (wk_s6.l > 16'd32768) ? (wk_s6.l - 16'd32768) : (16'd32768 - wk_s6.l);
		nx[7].ps = 25'((17'd65536 - wk_s6.s) * d);
		nx[7].pl = 23'(dl * c2);

		// s8: adjusted saturation and lightness
		nx[8] = wk_s7;
		if (wk_s7.s != 17'd0) begin
			nx[8].s = 17'(18'd65536 - 18'(wk_s7.ps >> 7));
			if (wk_s7.l > 16'd32768) nx[8].l = 16'(wk_s7.pl >> 7) + 16'd32768;
			else nx[8].l = 16'd32768 - 16'(wk_s7.pl >> 7);
		end

		// s9
		nx[9] = wk_s8;
		op = (wk_s8.l < 16'd32768) ? ({1'b0, wk_s8.s} + 18'd65536) : {1'b0, wk_s8.s};
		nx[9].pv = 34'(wk_s8.l * op);

		// s10: value and minimum terms
		nx[10] = wk_s9;
		if (wk_s9.l < 16'd32768) v19 = {2'd0, wk_s9.pv[32:16]};
		else v19 = {3'd0, wk_s9.l} + {2'd0, wk_s9.s} - {2'd0, wk_s9.pv[32:16]};
		nx[10].vv = v19[16:0];
		m19 = {2'd0, wk_s9.l, 1'b0} - {2'd0, v19[16:0]};
		nx[10].mm = m19[18] ? 17'd0 : m19[16:0];
		dv = v19[16:0] - nx[10].mm;
		nx[10].sd.rem = {1'b0, dv, 8'd0};
		nx[10].sd.q = '0;

		nx[11] = wk_s10;
		for (int i = 0; i < 3; i++)
			nx[11].sd = div_step(nx[11].sd, wk_s10.vv, 5'(8 - i));
		nx[12] = wk_s11;
		for (int i = 0; i < 3; i++)
			nx[12].sd = div_step(nx[12].sd, wk_s11.vv, 5'(5 - i));
		nx[13] = wk_s12;
		for (int i = 0; i < 3; i++)
			nx[13].sd = div_step(nx[13].sd, wk_s12.vv, 5'(2 - i));

		nx[14] = wk_s13;
		nx[14].p1 = 26'(wk_s13.vv * wk_s13.sd.q[8:0]);

		nx[15] = wk_s14;
		nx[15].p2 = 34'(wk_s14.p1 * wk_s14.h[7:0]);

		// s16: channel select
		nx[16] = wk_s15;
		vsf = wk_s15.p2[33:16];
		mid1 = {2'd0, wk_s15.mm} + {1'b0, vsf};
		mid2 = {2'd0, wk_s15.vv} - {1'b0, vsf};
		xv = {2'd0, wk_s15.vv};
		xm = {2'd0, wk_s15.mm};
		if (wk_s15.mode == MODE_BOOST) begin
			if (wk_s15.vv == 17'd0) begin
				nx[16].r = 8'd0; nx[16].g = 8'd0; nx[16].b = 8'd0;
			end else begin
				unique case (wk_s15.h[10:8])
					3'd1: begin
						nx[16].r = sat8(mid2); nx[16].g = sat8(xv); nx[16].b = sat8(xm);
					end
					3'd2: begin
						nx[16].r = sat8(xm); nx[16].g = sat8(xv); nx[16].b = sat8(mid1);
					end
					3'd3: begin
						nx[16].r = sat8(xm); nx[16].g = sat8(mid2); nx[16].b = sat8(xv);
					end
					3'd4: begin
						nx[16].r = sat8(mid1); nx[16].g = sat8(xm); nx[16].b = sat8(xv);
					end
					3'd5: begin
						nx[16].r = sat8(xv); nx[16].g = sat8(xm); nx[16].b = sat8(mid2);
					end
					default: begin
						nx[16].r = sat8(xv); nx[16].g = sat8(mid1); nx[16].b = sat8(xm);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[15:1], in_take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wk_s1 <= nx[1];   wk_s2 <= nx[2];   wk_s3 <= nx[3];   wk_s4 <= nx[4];
			wk_s5 <= nx[5];   wk_s6 <= nx[6];   wk_s7 <= nx[7];   wk_s8 <= nx[8];
			wk_s9 <= nx[9];   wk_s10 <= nx[10]; wk_s11 <= nx[11]; wk_s12 <= nx[12];
			wk_s13 <= nx[13]; wk_s14 <= nx[14]; wk_s15 <= nx[15]; wk_s16 <= nx[16];
		end
	end

endmodule
`default_nettype wire

// ===== bench/cva_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cva_checker
// Watches the vibrance, request and result channels of the color vibrance
// adjuster, predicts each adjusted color and compares it with what arrives.
// ---------------------------------------------------------------------------
module cva_checker
	import cva_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vibrance_valid,
	input  logic       vibrance_ready,
	input  logic [7:0] vibrance,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] red_out,
	input  logic [7:0] green_out,
	input  logic [7:0] blue_out,
	output int         errors,
	output int         pending
);

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic [7:0] vib_setting;
	rgb_t       expected_colors[$];

	function automatic logic [7:0] clamp_channel(input longint x);
		longint y;
		if (x < 0)
			return 8'd0;
		y = x >>> 8;
		return (y > 255) ? 8'd255 : y[7:0];
	endfunction

	function automatic rgb_t boost_color(input logic [7:0] vib, input rgb_t c);
		int unsigned r, g, b, v, m, h, s, l, vm, d, c2, den, r2, g2, b2;
		longint      lv, sl, bv, bm, sv, fr, vsf, lo, hi;
		rgb_t        o;
		r = c.r;
		g = c.g;
		b = c.b;
		v = (r > g) ? r : g;
		m = (r < g) ? r : g;
		if (b > v) v = b;
		if (b < m) m = b;
		h = 0;
		s = 0;
		d = 256 - vib;
		c2 = (d >> 1) + 64;
		l = (m + v) << 7;
		vm = v - m;
		if (l != 0 && vm != 0) begin
			den = (l < 32768) ? (v + m) : (512 - v - m);
			r2 = (((v - r) << 16) / vm) >> 8;
			g2 = (((v - g) << 16) / vm) >> 8;
			b2 = (((v - b) << 16) / vm) >> 8;
			s = (vm << 16) / den;
			if (r == v)
				h = (g == m) ? 1280 + b2 : 256 - g2;
			else if (g == v)
				h = (b == m) ? 256 + r2 : 768 - b2;
			else
				h = (r == m) ? 768 + g2 : 1280 - r2;
		end
		if (s != 0) begin
			s = 65536 - (((65536 - s) * d) >> 7);
			if (l > 32768)
				l = (((l - 32768) * c2) >> 7) + 32768;
			else
				l = 32768 - (((32768 - l) * c2) >> 7);
		end
		lv = longint'(l);
		sl = longint'(s);
		if (l < 32768)
			bv = (lv * (sl + 65536)) >>> 16;
		else
			bv = lv + sl - ((lv * sl) >>> 16);
		if (bv <= 0)
			return '0;
		bm = 2 * lv - bv;
		if (bm < 0) bm = 0;
		sv = ((bv - bm) * 256) / bv;
		fr = longint'(h & 255);
		vsf = (bv * sv * fr) >>> 16;
		lo = bm + vsf;
		hi = bv - vsf;
		case (h >> 8)
			1: o = '{clamp_channel(hi), clamp_channel(bv), clamp_channel(bm)};
			2: o = '{clamp_channel(bm), clamp_channel(bv), clamp_channel(lo)};
			3: o = '{clamp_channel(bm), clamp_channel(hi), clamp_channel(bv)};
			4: o = '{clamp_channel(lo), clamp_channel(bm), clamp_channel(bv)};
			5: o = '{clamp_channel(bv), clamp_channel(bm), clamp_channel(hi)};
			default: o = '{clamp_channel(bv), clamp_channel(lo), clamp_channel(bm)};
		endcase
		return o;
	endfunction

	function automatic rgb_t adjust_color(input logic [7:0] vib, input rgb_t c);
		int unsigned gray, k;
		rgb_t        o;
		if (vib == VIB_NEUTRAL)
			return c;
		if (vib > VIB_NEUTRAL)
			return boost_color(vib, c);
		k = vib;
		gray = (c.b * 77 + c.r * 84 + c.g * 95) >> 8;
		o.r = 8'((k * c.r + (127 - k) * gray) >> 7);
		o.g = 8'((k * c.g + (127 - k) * gray) >> 7);
		o.b = 8'((k * c.b + (127 - k) * gray) >> 7);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t want;
		if (!arst_n) begin
			vib_setting = VIB_NEUTRAL;
			expected_colors.delete();
			errors = 0;
		end else begin
			if (vibrance_valid && vibrance_ready)
				vib_setting = vibrance;
			if (push && !full)
				expected_colors.push_back(adjust_color(vib_setting, '{red_in, green_in, blue_in}));
			if (pop && !empty) begin
				if (expected_colors.size() == 0) begin
					$error("result with no request outstanding: %0d %0d %0d",
						red_out, green_out, blue_out);
					errors++;
				end else begin
					want = expected_colors.pop_front();
					if (red_out !== want.r) begin
						$error("red_out expected %0d actual %0d", want.r, red_out);
						errors++;
					end
					if (green_out !== want.g) begin
						$error("green_out expected %0d actual %0d", want.g, green_out);
						errors++;
					end
					if (blue_out !== want.b) begin
						$error("blue_out expected %0d actual %0d", want.b, blue_out);
						errors++;
					end
				end
			end
		end
		pending = expected_colors.size();
	end

endmodule

// ===== bench/tb_color_vibrance_adjust.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_color_vibrance_adjust
// Drives colors and vibrance settings into the color vibrance adjuster under
// random sender and receiver idling; the checker judges every result.
// ---------------------------------------------------------------------------
module tb_color_vibrance_adjust
	import cva_pkg::*;
();

	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 3000;

	logic       clk;
	logic       arst_n;
	logic       vibrance_valid;
	logic       vibrance_ready;
	logic [7:0] vibrance;
	logic       push;
	logic       full;
	logic [7:0] red_in, green_in, blue_in;
	logic       empty;
	logic       pop;
	logic [7:0] red_out, green_out, blue_out;
	int         errors;
	int         pending;
	int         send_idle;
	int         recv_idle;
	int         hold_left;
	int         quiet_cycles;

	color_vibrance_adjust i_dut (.*);

	cva_checker i_checker (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		vibrance_valid = 1'b0;
		vibrance = VIB_NEUTRAL;
		push = 1'b0;
		red_in = '0;
		green_in = '0;
		blue_in = '0;
		pop = 1'b0;
		send_idle = 0;
		recv_idle = 0;
		hold_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: random pops, with one long hold
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (vibrance_valid && vibrance_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_color(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		bit granted;
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do begin
			@(negedge clk);
			granted = !full;
			@(posedge clk);
		end while (!granted);
	endtask

	task automatic drain;
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_vibrance(input logic [7:0] value);
		bit granted;
		drain();
		vibrance_valid <= 1'b1;
		vibrance <= value;
		do begin
			@(negedge clk);
			granted = vibrance_ready;
			@(posedge clk);
		end while (!granted);
		vibrance_valid <= 1'b0;
	endtask

	task automatic send_random_color;
		logic [7:0] r, g, b;
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		case ($urandom_range(9))
			0: begin g = r; b = r; end
			1: g = r;
			2: b = g;
			3: begin r = 8'd255; b = 8'd0; end
			4: begin g = 8'd0; b = 8'd255 - 8'($urandom_range(3)); end
			default: ;
		endcase
		send_color(r, g, b);
	endtask

	logic [23:0] corner_colors[16] = '{
		24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00,
		24'h00ffff, 24'hff00ff, 24'h808080, 24'h010000, 24'hfffefe, 24'hff0001,
		24'h7f807f, 24'h01ff00, 24'hc0ff10, 24'h10ffc0
	};

	logic [7:0] settings[12] = '{
		8'd128, 8'd255, 8'd0, 8'd129, 8'd127, 8'd1,
		8'd254, 8'd128, 8'd200, 8'd64, 8'd160, 8'd100
	};

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		write_vibrance(8'd255);
		foreach (corner_colors[i])
			send_color(corner_colors[i][23:16], corner_colors[i][15:8], corner_colors[i][7:0]);
		write_vibrance(8'd0);
		for (int i = 0; i < 6; i++)
			send_color(corner_colors[i][23:16], corner_colors[i][15:8], corner_colors[i][7:0]);
		foreach (settings[ph]) begin
			if (ph < 4) begin
				send_idle = 30;
				recv_idle = 69;
			end else if (ph < 8) begin
				send_idle = 69;
				recv_idle = 30;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_vibrance(ph >= 10 ? 8'($urandom) : settings[ph]);
			if (ph == 1)
				hold_left = 300;
			for (int n = 0; n < 128; n++)
				send_random_color();
		end
		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
